// ===== rtl/equirect_sky_pixel_index_assert.svh =====
// Assertion macros for the checker file of the sky lookup block.
`ifndef EQUIRECT_SKY_PIXEL_INDEX_ASSERT_SVH
`define EQUIRECT_SKY_PIXEL_INDEX_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define ESPI_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("sky lookup check failed");

// Condition must never be seen outside reset.
`define ESPI_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("sky lookup illegal condition");

`endif

// ===== rtl/espi_pkg.sv =====
// ----------------------------------------------------------------------------
// espi_pkg
// Shared types, constants and the CORDIC angle table of the sky lookup.
// ----------------------------------------------------------------------------
package espi_pkg;

  localparam int unsigned ROW_W     = 48;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned COEF_FRAC = 14;
  localparam int unsigned OFS_W     = 16;
  localparam int unsigned DIMREG_W  = 13;
  localparam int unsigned ANG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [ANG_W-1:0] HALF_TURN = 16'h8000;
  localparam logic [15:0]      HYP_GAIN  = 16'd39797;

  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_U   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_V   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 3'd6;

  typedef struct packed {
    logic [2:0][ROW_W-1:0] rot_row;
    logic [OFS_W-1:0]      ofs_u;
    logic [OFS_W-1:0]      ofs_v;
    logic [DIMREG_W-1:0]   map_width;
    logic [DIMREG_W-1:0]   map_height;
  } cfg_t;

  function automatic logic [ANG_W-1:0] atan_turn(input int unsigned i);
    logic [ANG_W-1:0] t;
    case (i)
      0:  t = 16'd8192;
      1:  t = 16'd4836;
      2:  t = 16'd2555;
      3:  t = 16'd1297;
      4:  t = 16'd651;
      5:  t = 16'd326;
      6:  t = 16'd163;
      7:  t = 16'd81;
      8:  t = 16'd41;
      9:  t = 16'd20;
      10: t = 16'd10;
      11: t = 16'd5;
      12: t = 16'd3;
      13: t = 16'd1;
      14: t = 16'd1;
      default: t = 16'd0;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/equirect_sky_pixel_index.sv =====
// ----------------------------------------------------------------------------
// equirect_sky_pixel_index
// Maps a ray direction to a pixel of an equirectangular sky map.
// ----------------------------------------------------------------------------
// Request channel: drive dir_x_i/dir_y_i/dir_z_i with start; a request is
// taken at a clock edge where start is high and busy is low.
// Result channel: pixel_col_o/pixel_row_o are shown for one cycle with
// res_valid_o high; the receiver takes them at that edge and cannot stall.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// write only while no request is in flight.
// Throughput: one request per cycle, sustained; busy stays low since the
// back end drains the queue every cycle.
// Path: two rotation stages, the queue, two CORDIC pipelines of
// ANGLE_ITERATIONS+1 stages, hypot scale and the output multiply.
// Reset: identity matrix, zero offsets, 4096x2048 map, pipeline emptied.
// ----------------------------------------------------------------------------
module equirect_sky_pixel_index import espi_pkg::*; #(
  parameter int unsigned DIR_WIDTH        = 24,
  parameter int unsigned ANGLE_ITERATIONS = 16,
  parameter int unsigned MAP_DIM_BITS     = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [DIR_WIDTH-1:0] dir_x_i,
  input  logic signed [DIR_WIDTH-1:0] dir_y_i,
  input  logic signed [DIR_WIDTH-1:0] dir_z_i,
  output logic                        res_valid_o,
  output logic [MAP_DIM_BITS-1:0]     pixel_col_o,
  output logic [MAP_DIM_BITS-1:0]     pixel_row_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [ROW_W-1:0]            cfg_data_i
);

  localparam int unsigned QW = 3 * (DIR_WIDTH + 4);

  cfg_t cfg_q;
  logic accept;
  logic f_valid, q_valid, q_full;
  logic [QW-1:0] f_rot, q_rot;

  assign cfg_ready_o = 1'b1;
  assign busy        = q_full;
  assign accept      = start && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot_row[0]  <= 48'h4000_0000_0000;
      cfg_q.rot_row[1]  <= 48'h0000_4000_0000;
      cfg_q.rot_row[2]  <= 48'h0000_0000_4000;
      cfg_q.ofs_u       <= '0;
      cfg_q.ofs_v       <= '0;
      cfg_q.map_width   <= 13'd4096;
      cfg_q.map_height  <= 13'd2048;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ROT_ROW0:   cfg_q.rot_row[0] <= cfg_data_i;
        REG_ROT_ROW1:   cfg_q.rot_row[1] <= cfg_data_i;
        REG_ROT_ROW2:   cfg_q.rot_row[2] <= cfg_data_i;
        REG_OFFSET_U:   cfg_q.ofs_u      <= cfg_data_i[OFS_W-1:0];
        REG_OFFSET_V:   cfg_q.ofs_v      <= cfg_data_i[OFS_W-1:0];
        REG_MAP_WIDTH:  cfg_q.map_width  <= cfg_data_i[DIMREG_W-1:0];
        REG_MAP_HEIGHT: cfg_q.map_height <= cfg_data_i[DIMREG_W-1:0];
        default: ;
      endcase
    end
  end

  espi_front #(.DIR_WIDTH(DIR_WIDTH)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (accept),
    .dir_x_i (dir_x_i),
    .dir_y_i (dir_y_i),
    .dir_z_i (dir_z_i),
    .valid_o (f_valid),
    .rot_o   (f_rot)
  );

  espi_queue #(.DATA_W(QW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  (f_rot),
    .pop_i   (1'b1),
    .valid_o (q_valid),
    .data_o  (q_rot),
    .full_o  (q_full)
  );

  espi_back #(
    .DIR_WIDTH        (DIR_WIDTH),
    .ANGLE_ITERATIONS (ANGLE_ITERATIONS),
    .MAP_DIM_BITS     (MAP_DIM_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .valid_i     (q_valid),
    .rot_i       (q_rot),
    .valid_o     (res_valid_o),
    .pixel_col_o (pixel_col_o),
    .pixel_row_o (pixel_row_o)
  );

endmodule

// ===== rtl/espi_front.sv =====
// ----------------------------------------------------------------------------
// espi_front
// Accepts directions and rotates them by the sky matrix in two stages.
// ----------------------------------------------------------------------------
module espi_front import espi_pkg::*; #(
  parameter int unsigned DIR_WIDTH = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cfg_t                        cfg_i,
  input  logic                        valid_i,
  input  logic signed [DIR_WIDTH-1:0] dir_x_i,
  input  logic signed [DIR_WIDTH-1:0] dir_y_i,
  input  logic signed [DIR_WIDTH-1:0] dir_z_i,
  output logic                        valid_o,
  output logic [3*(DIR_WIDTH+4)-1:0]  rot_o
);

  localparam int unsigned PW = DIR_WIDTH + COEF_W;
  localparam int unsigned SW = DIR_WIDTH + COEF_W + 2;
  localparam int unsigned RW = DIR_WIDTH + 4;

  logic signed [DIR_WIDTH-1:0] dir [3];
  logic signed [PW-1:0] prod_d [3][3];
  logic signed [PW-1:0] prod_q [3][3];
  logic signed [SW-1:0] sum [3];
  logic [3*RW-1:0] rot_d, rot_q;
  logic v1_q, v2_q;

  assign dir[0] = dir_x_i;
  assign dir[1] = dir_y_i;
  assign dir[2] = dir_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        prod_d[i][k] = $signed(cfg_i.rot_row[i][(2-k)*COEF_W +: COEF_W]) * dir[k];
      end
    end
  end

  always_comb begin
    rot_d = '0;
    for (int i = 0; i < 3; i++) begin
      sum[i] = SW'(prod_q[i][0]) + SW'(prod_q[i][1]) + SW'(prod_q[i][2]);
      rot_d[(2-i)*RW +: RW] = sum[i][COEF_FRAC +: RW];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rot_q  <= rot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign valid_o = v2_q;
  assign rot_o   = rot_q;

endmodule

// ===== rtl/espi_queue.sv =====
// ----------------------------------------------------------------------------
// espi_queue
// Two-entry queue between the rotation front and the angle back end.
// ----------------------------------------------------------------------------
module espi_queue #(
  parameter int unsigned DATA_W = 84
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o,
  output logic              full_o
);

  logic [DATA_W-1:0] mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_pop;

  assign do_pop  = pop_i && (cnt_q != 2'd0);
  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(do_pop);
    end
  end

endmodule

// ===== rtl/espi_cordic.sv =====
// ----------------------------------------------------------------------------
// espi_cordic
// Pipelined CORDIC vectoring: angle in 2^-16 turn and scaled magnitude.
// ----------------------------------------------------------------------------
module espi_cordic import espi_pkg::*; #(
  parameter int unsigned W     = 31,
  parameter int unsigned ITERS = 16,
  parameter int unsigned SBW   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic signed [W-1:0] x_i,
  input  logic signed [W-1:0] y_i,
  input  logic [SBW-1:0]      sb_i,
  output logic                valid_o,
  output logic [ANG_W-1:0]    ang_o,
  output logic signed [W-1:0] mag_o,
  output logic [SBW-1:0]      sb_o
);

  logic signed [W-1:0] x_q [ITERS+1];
  logic signed [W-1:0] y_q [ITERS+1];
  logic [ANG_W-1:0]    a_q [ITERS+1];
  logic                z_q [ITERS+1];
  logic [SBW-1:0]      s_q [ITERS+1];
  logic                v_q [ITERS+1];

  always_ff @(posedge clk_i) begin
    x_q[0] <= x_i[W-1] ? -x_i : x_i;
    y_q[0] <= x_i[W-1] ? -y_i : y_i;
    a_q[0] <= x_i[W-1] ? HALF_TURN : '0;
    z_q[0] <= (x_i == '0) && (y_i == '0);
    s_q[0] <= sb_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  for (genvar i = 0; i < ITERS; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (!y_q[i][W-1]) begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        a_q[i+1] <= a_q[i] + atan_turn(i);
      end else begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        a_q[i+1] <= a_q[i] - atan_turn(i);
      end
      z_q[i+1] <= z_q[i];
      s_q[i+1] <= s_q[i];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= v_q[i];
      end
    end
  end

  assign valid_o = v_q[ITERS];
  assign ang_o   = z_q[ITERS] ? '0 : a_q[ITERS];
  assign mag_o   = x_q[ITERS];
  assign sb_o    = s_q[ITERS];

endmodule

// ===== rtl/espi_back.sv =====
// ----------------------------------------------------------------------------
// espi_back
// Two CORDIC passes, hypot scaling, offsets and pixel scaling.
// ----------------------------------------------------------------------------
module espi_back import espi_pkg::*; #(
  parameter int unsigned DIR_WIDTH        = 24,
  parameter int unsigned ANGLE_ITERATIONS = 16,
  parameter int unsigned MAP_DIM_BITS     = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfg_t                       cfg_i,
  input  logic                       valid_i,
  input  logic [3*(DIR_WIDTH+4)-1:0] rot_i,
  output logic                       valid_o,
  output logic [MAP_DIM_BITS-1:0]    pixel_col_o,
  output logic [MAP_DIM_BITS-1:0]    pixel_row_o
);

  localparam int unsigned RW = DIR_WIDTH + 4;
  localparam int unsigned W  = RW + 3;
  localparam int unsigned DW = MAP_DIM_BITS + 1;
  localparam logic [15:0] DIM_TOP = 16'(1) << MAP_DIM_BITS;

  logic signed [RW-1:0] r0, r1, r2;
  logic                 va;
  logic [ANG_W-1:0]     au;
  logic signed [W-1:0]  mag_a;
  logic [RW-1:0]        r1_a;
  logic signed [W+16:0] hprod;
  logic signed [W-1:0]  hyp_q;
  logic signed [RW-1:0] r1_q;
  logic [ANG_W-1:0]     au_q;
  logic                 vh_q;
  logic                 vb;
  logic [ANG_W-1:0]     av;
  logic signed [W-1:0]  mag_b;
  logic [ANG_W-1:0]     au_b;
  logic [ANG_W-1:0]     uu, vv;
  logic [15:0]          wreg, hreg, wdim, hdim;
  logic [16+DW-1:0]     pc, pr;
  logic                 vo_q;
  logic [MAP_DIM_BITS-1:0] col_q, row_q;

  assign r0 = rot_i[2*RW +: RW];
  assign r1 = rot_i[RW +: RW];
  assign r2 = rot_i[0 +: RW];

  espi_cordic #(.W(W), .ITERS(ANGLE_ITERATIONS), .SBW(RW)) u_cordic_u (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .x_i     (W'(r0)),
    .y_i     (W'(r2)),
    .sb_i    (r1),
    .valid_o (va),
    .ang_o   (au),
    .mag_o   (mag_a),
    .sb_o    (r1_a)
  );

  assign hprod = mag_a * $signed({1'b0, HYP_GAIN});

  always_ff @(posedge clk_i) begin
    hyp_q <= hprod[16 +: W];
    r1_q  <= r1_a;
    au_q  <= au;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vh_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      vh_q <= va;
      vo_q <= vb;
    end
  end

  espi_cordic #(.W(W), .ITERS(ANGLE_ITERATIONS), .SBW(ANG_W)) u_cordic_v (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vh_q),
    .x_i     (hyp_q),
    .y_i     (W'(r1_q)),
    .sb_i    (au_q),
    .valid_o (vb),
    .ang_o   (av),
    .mag_o   (mag_b),
    .sb_o    (au_b)
  );

  always_comb begin
    wreg = 16'(cfg_i.map_width);
    hreg = 16'(cfg_i.map_height);
    wdim = (wreg == 16'd0) ? 16'd1 : ((wreg > DIM_TOP) ? DIM_TOP : wreg);
    hdim = (hreg == 16'd0) ? 16'd1 : ((hreg > DIM_TOP) ? DIM_TOP : hreg);
    uu   = HALF_TURN - au_b + cfg_i.ofs_u;
    vv   = HALF_TURN - {av[ANG_W-2:0], 1'b0} + cfg_i.ofs_v;
    pc   = uu * wdim[DW-1:0];
    pr   = vv * hdim[DW-1:0];
  end

  always_ff @(posedge clk_i) begin
    col_q <= pc[16 +: MAP_DIM_BITS];
    row_q <= pr[16 +: MAP_DIM_BITS];
  end

  assign valid_o     = vo_q;
  assign pixel_col_o = col_q;
  assign pixel_row_o = row_q;

endmodule

// ===== rtl/espi_checker.sv =====
// ----------------------------------------------------------------------------
// espi_checker
// Port-level checks on request and result counts and on config ready of the sky lookup.
// ----------------------------------------------------------------------------
`include "equirect_sky_pixel_index_assert.svh"

module espi_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic res_valid_o,
  input logic cfg_ready_o
);

  logic [7:0] pend_q;
  logic       acc;

  assign acc = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 8'(acc) - 8'(res_valid_o);
    end
  end

  `ESPI_ASSERT(a_res_has_req, clk_i, rst_ni, res_valid_o |-> (pend_q != 8'd0))
  `ESPI_ASSERT(a_busy_has_req, clk_i, rst_ni, busy |-> (pend_q != 8'd0))
  `ESPI_NEVER(a_pend_wrap, clk_i, rst_ni, (pend_q == 8'hff) && acc && !res_valid_o)
  `ESPI_ASSERT(a_cfg_ready, clk_i, rst_ni, $past(cfg_ready_o) |-> cfg_ready_o)

endmodule

bind equirect_sky_pixel_index espi_checker u_espi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .cfg_ready_o (cfg_ready_o)
);
